/* hw/rtl/lud_pkg.sv */
// lud_pkg: shared constants and control types of the lu factorization block
// no dependencies
`default_nettype none

package lud_pkg;

  // fixed widths of the request and result fields, default and reset order, q16.16 one
  localparam int unsigned ORDER_W         = 4;
  localparam int unsigned POS_W           = 3;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned DEF_MAX_ORDER   = 8;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  // commands from controller to datapath
  typedef struct packed {
    logic rd_en;
    logic use_k;
    logic acc_clr;
    logic mul_en;
    logic acc_en;
    logic diff_en;
    logic diag;
    logic u_wr;
    logic div_start;
    logic l_wr;
    logic err_clr;
    logic out_load;
    logic out_last;
  } lud_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic piv_zero;
    logic out_free;
  } lud_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/lud_divider.sv */
// lud_divider: q16.16 divide, rounded to nearest, ties away from zero, saturated
// radix-2 restoring divider, one quotient bit per cycle; uses lud_pkg
`default_nettype none

module lud_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [lud_pkg::DATA_W-1:0] num,
  input  wire logic signed [lud_pkg::DATA_W-1:0] den,
  output logic                               done,
  output logic signed [lud_pkg::DATA_W-1:0]  quo
);
  import lud_pkg::*;

  localparam int unsigned QW = DATA_W + 16;
  localparam int unsigned CW = $clog2(QW);

  logic [DATA_W-1:0] ud_r;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r, neg_r;
  logic [DATA_W:0]   trial;
  logic              qbit;
  logic [DATA_W-1:0] un, ud;

  // magnitudes of the operands
  assign un = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
  assign ud = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);

  // one restoring step
  always_comb begin
    trial   = {rem_r, quo_r[QW-1]};
    qbit    = (trial >= {1'b0, ud_r});
    rem_nxt = qbit ? DATA_W'(trial - {1'b0, ud_r}) : DATA_W'(trial);
    quo_nxt = {quo_r[QW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operand load and iteration
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DATA_W-1] ^ den[DATA_W-1];
      ud_r  <= ud;
      rem_r <= '0;
      quo_r <= QW'({un, 16'h0000}) + QW'(ud >> 1);
      cnt_r <= CW'(QW - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // sign and saturation
  always_comb begin
    if (neg_r) begin
      if (quo_r > QW'(33'h0_8000_0000)) quo = 32'sh8000_0000;
      else                              quo = DATA_W'(-quo_r);
    end else begin
      if (quo_r > QW'(32'h7FFF_FFFF))   quo = 32'sh7FFF_FFFF;
      else                              quo = DATA_W'(quo_r);
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

/* hw/rtl/lud_datapath.sv */
// lud_datapath: matrix stores, multiply-accumulate, divider and result register
// driven by lud_ctrl commands; uses lud_pkg and lud_divider
`default_nettype none

module lud_datapath #(
  parameter int unsigned MAX_ORDER = lud_pkg::DEF_MAX_ORDER,
  parameter int unsigned IW        = $clog2(MAX_ORDER)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lud_pkg::lud_cmd_t                 cmd,
  input  wire logic [IW-1:0]                     tr,
  input  wire logic [IW-1:0]                     tc,
  input  wire logic [IW-1:0]                     k,
  output lud_pkg::lud_stat_t                     stat,
  input  wire logic                              ld_en,
  input  wire logic [lud_pkg::POS_W-1:0]         ld_row,
  input  wire logic [lud_pkg::POS_W-1:0]         ld_col,
  input  wire logic signed [lud_pkg::DATA_W-1:0] ld_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [lud_pkg::POS_W-1:0]              out_row,
  output logic [lud_pkg::POS_W-1:0]              out_col,
  output logic signed [lud_pkg::DATA_W-1:0]      out_lower_value,
  output logic signed [lud_pkg::DATA_W-1:0]      out_upper_value,
  output logic                                   out_status,
  output logic                                   out_run_end
);
  import lud_pkg::*;

  localparam int unsigned DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ACC_W = 2 * DATA_W - 16 + $clog2(MAX_ORDER) + 1;

  logic signed [DATA_W-1:0] a_mem [DEPTH];
  logic signed [DATA_W-1:0] l_mem [DEPTH];
  logic signed [DATA_W-1:0] u_mem [DEPTH];

  logic signed [DATA_W-1:0]   a_q_r, l_q_r, u_q_r;
  logic signed [2*DATA_W-1:0] prod_r, prod_rnd;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W:0]      diff_wide;
  logic signed [DATA_W-1:0]   diff_r, diff_sat, piv_r;
  logic                       err_r, out_valid_r;
  logic [AW-1:0]              pos_addr, l_ra, u_ra, ld_addr;
  logic                       ld_ok;
  logic                       div_done;
  logic signed [DATA_W-1:0]   div_q;

  function automatic logic [AW-1:0] addr_of(input int unsigned r, input int unsigned c);
    addr_of = AW'(r * MAX_ORDER + c);
  endfunction

  // addresses
  assign pos_addr = addr_of(tr, tc);
  assign l_ra     = cmd.use_k ? addr_of(tr, k) : pos_addr;
  assign u_ra     = cmd.use_k ? addr_of(k, tc) : pos_addr;
  assign ld_ok    = (int'(ld_row) < MAX_ORDER) && (int'(ld_col) < MAX_ORDER);
  assign ld_addr  = addr_of(ld_row, ld_col);

  // source store
  always_ff @(posedge clk) begin
    if (ld_en && ld_ok) a_mem[ld_addr] <= ld_data;
    if (cmd.rd_en) a_q_r <= a_mem[pos_addr];
  end

  // lower store
  always_ff @(posedge clk) begin
    if (cmd.l_wr) l_mem[pos_addr] <= (piv_r == '0) ? '0 : div_q;
    if (cmd.rd_en) l_q_r <= l_mem[l_ra];
  end

  // upper store
  always_ff @(posedge clk) begin
    if (cmd.u_wr) u_mem[pos_addr] <= diff_r;
    if (cmd.rd_en) u_q_r <= u_mem[u_ra];
  end

  // multiply, round to q16.16, accumulate
  assign prod_rnd = (prod_r + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= l_q_r * u_q_r;
    if (cmd.acc_clr)     acc_r <= '0;
    else if (cmd.acc_en) acc_r <= acc_r + ACC_W'(prod_rnd);
  end

  // difference with saturation
  always_comb begin
    diff_wide = (ACC_W+1)'(a_q_r) - (ACC_W+1)'(acc_r);
    if (diff_wide > (ACC_W+1)'(32'sh7FFF_FFFF))       diff_sat = 32'sh7FFF_FFFF;
    else if (diff_wide < (ACC_W+1)'(32'sh8000_0000))  diff_sat = 32'sh8000_0000;
    else                                              diff_sat = DATA_W'(diff_wide);
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_en) diff_r <= diff_sat;
    if (cmd.u_wr && cmd.diag) piv_r <= diff_r;
  end

  // zero pivot flag, also set by a zero diagonal source entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (cmd.err_clr) begin
      err_r <= 1'b0;
    end else if ((cmd.diff_en && cmd.diag && a_q_r == '0) ||
                 (cmd.u_wr && cmd.diag && diff_r == '0)) begin
      err_r <= 1'b1;
    end
  end

  lud_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (diff_r),
    .den   (piv_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row         <= POS_W'(tr);
      out_col         <= POS_W'(tc);
      out_lower_value <= (tr == tc) ? Q_ONE : ((tr < tc) ? '0 : l_q_r);
      out_upper_value <= (tr > tc) ? '0 : u_q_r;
      out_status      <= err_r;
      out_run_end     <= cmd.out_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.div_done = div_done;
  assign stat.piv_zero = (piv_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

/* hw/rtl/lud_ctrl.sv */
// lud_ctrl: sequencer for loading, factoring and streaming out results
// drives lud_datapath commands; uses lud_pkg
`default_nettype none

module lud_ctrl #(
  parameter int unsigned MAX_ORDER = lud_pkg::DEF_MAX_ORDER,
  parameter int unsigned IW        = $clog2(MAX_ORDER)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_final,
  output logic                             in_stall,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lud_pkg::ORDER_W-1:0] cfg_wr_data,
  output lud_pkg::lud_cmd_t                cmd,
  output logic [IW-1:0]                    tr,
  output logic [IW-1:0]                    tc,
  output logic [IW-1:0]                    k,
  input  wire lud_pkg::lud_stat_t          stat
);
  import lud_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_JOB  = 4'd1;
  localparam logic [3:0] S_RDK  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_RDA  = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_UWR  = 4'd7;
  localparam logic [3:0] S_LDIV = 4'd8;
  localparam logic [3:0] S_DIVW = 4'd9;
  localparam logic [3:0] S_ORD  = 4'd10;
  localparam logic [3:0] S_OLD  = 4'd11;

  logic [3:0]         st_r, st_nxt;
  logic [ORDER_W-1:0] order_r;
  logic [IW-1:0]      nm1_r, nm1_nxt;
  logic [IW-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic               ph_r, ph_nxt;
  logic               adv;
  logic               last_pos;

  // matrix order register
  always_ff @(posedge clk) begin
    if (!rst_n)         order_r <= ORDER_RESET;
    else if (cfg_wr_en) order_r <= cfg_wr_data;
  end

  // lower phase works on (j, i), upper and output on (i, j)
  assign tr       = ph_r ? j_r : i_r;
  assign tc       = ph_r ? i_r : j_r;
  assign k        = k_r;
  assign in_stall = (st_r != S_IDLE);
  assign last_pos = (i_r == nm1_r) && (j_r == nm1_r);

  always_comb begin
    st_nxt  = st_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    ph_nxt  = ph_r;
    nm1_nxt = nm1_r;
    adv     = 1'b0;
    cmd     = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid && in_final) begin
          if (order_r == '0)                  nm1_nxt = '0;
          else if (int'(order_r) > MAX_ORDER) nm1_nxt = IW'(MAX_ORDER - 1);
          else                                nm1_nxt = IW'(order_r - 1'b1);
          i_nxt       = '0;
          j_nxt       = '0;
          ph_nxt      = 1'b0;
          cmd.err_clr = 1'b1;
          st_nxt      = S_JOB;
        end
      end
      S_JOB: begin
        cmd.acc_clr = 1'b1;
        k_nxt       = '0;
        st_nxt      = (i_r == '0) ? S_RDA : S_RDK;
      end
      S_RDK: begin
        cmd.rd_en = 1'b1;
        cmd.use_k = 1'b1;
        st_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        st_nxt     = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        k_nxt      = IW'(k_r + 1'b1);
        st_nxt     = (IW'(k_r + 1'b1) == i_r) ? S_RDA : S_RDK;
      end
      S_RDA: begin
        cmd.rd_en = 1'b1;
        st_nxt    = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        cmd.diag    = !ph_r && (i_r == j_r);
        st_nxt      = ph_r ? S_LDIV : S_UWR;
      end
      S_UWR: begin
        cmd.u_wr = 1'b1;
        cmd.diag = (i_r == j_r);
        adv      = 1'b1;
      end
      S_LDIV: begin
        if (stat.piv_zero) begin
          cmd.l_wr = 1'b1;
          adv      = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          st_nxt        = S_DIVW;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.l_wr = 1'b1;
          adv      = 1'b1;
        end
      end
      S_ORD: begin
        cmd.rd_en = 1'b1;
        st_nxt    = S_OLD;
      end
      S_OLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last_pos;
          if (last_pos) begin
            st_nxt = S_IDLE;
          end else begin
            st_nxt = S_ORD;
            if (j_r == nm1_r) begin
              j_nxt = '0;
              i_nxt = IW'(i_r + 1'b1);
            end else begin
              j_nxt = IW'(j_r + 1'b1);
            end
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // step to the next computed entry
    if (adv) begin
      st_nxt = S_JOB;
      if (!ph_r) begin
        if (j_r == nm1_r) begin
          if (i_r == nm1_r) begin
            i_nxt  = '0;
            j_nxt  = '0;
            st_nxt = S_ORD;
          end else begin
            ph_nxt = 1'b1;
            j_nxt  = IW'(i_r + 1'b1);
          end
        end else begin
          j_nxt = IW'(j_r + 1'b1);
        end
      end else begin
        if (j_r == nm1_r) begin
          ph_nxt = 1'b0;
          i_nxt  = IW'(i_r + 1'b1);
          j_nxt  = IW'(i_r + 1'b1);
        end else begin
          j_nxt = IW'(j_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ph_r  <= 1'b0;
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= '0;
      nm1_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ph_r  <= ph_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      k_r   <= k_nxt;
      nm1_r <= nm1_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lu_doolittle_decompose.sv */
// lu_doolittle_decompose: top level of the doolittle lu factorization block
// instantiates lud_ctrl and lud_datapath; uses lud_pkg
//
// usage:
//  - cfg_wr_en / cfg_wr_data set the matrix order n (0 acts as 1, above
//    MAX_ORDER acts as MAX_ORDER); reset value 4; write only while idle
//  - input channel (in_valid / in_stall): one request per matrix entry,
//    q16.16; positions outside MAX_ORDER are dropped; a request with
//    in_final_entry set is stored and then starts the factorization
//  - plain entry requests are taken whenever in_stall is low
//  - a final request is followed by the factorization on one shared
//    multiply-accumulate unit (each product passes the read, multiply and
//    accumulate states) and one radix-2 divider for the L entries
//  - then n*n results stream out in row-major order, last one flagged by
//    out_run_end; out_status flags a zero pivot or a zero source diagonal
//  - in_stall stays high from the final request until the last result is
//    in the output register; the next request is taken while it waits
//  - out_stall holds the output register; the sequencer waits on it
//  - reset (rst_n low, synchronous) clears control state and the output
//    valid; matrix stores are undefined until loaded
`default_nettype none

module lu_doolittle_decompose #(
  parameter int unsigned MAX_ORDER = lud_pkg::DEF_MAX_ORDER
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lud_pkg::POS_W-1:0]         in_row_index,
  input  wire logic [lud_pkg::POS_W-1:0]         in_col_index,
  input  wire logic signed [lud_pkg::DATA_W-1:0] in_entry_value,
  input  wire logic                              in_final_entry,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lud_pkg::ORDER_W-1:0]       cfg_wr_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [lud_pkg::POS_W-1:0]              out_row,
  output logic [lud_pkg::POS_W-1:0]              out_col,
  output logic signed [lud_pkg::DATA_W-1:0]      out_lower_value,
  output logic signed [lud_pkg::DATA_W-1:0]      out_upper_value,
  output logic                                   out_status,
  output logic                                   out_run_end
);
  import lud_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ORDER);

  lud_cmd_t      cmd;
  lud_stat_t     stat;
  logic [IW-1:0] tr, tc, k;

  lud_ctrl #(.MAX_ORDER(MAX_ORDER), .IW(IW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_final    (in_final_entry),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .tr          (tr),
    .tc          (tc),
    .k           (k),
    .stat        (stat)
  );

  lud_datapath #(.MAX_ORDER(MAX_ORDER), .IW(IW)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .tr              (tr),
    .tc              (tc),
    .k               (k),
    .stat            (stat),
    .ld_en           (in_valid && !in_stall),
    .ld_row          (in_row_index),
    .ld_col          (in_col_index),
    .ld_data         (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_lower_value (out_lower_value),
    .out_upper_value (out_upper_value),
    .out_status      (out_status),
    .out_run_end     (out_run_end)
  );

endmodule

`default_nettype wire

/* hw/rtl/lud_checker.sv */
// lud_checker: port-level checks of the lu factorization block
// bound to lu_doolittle_decompose; uses lud_pkg
`default_nettype none

module lud_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [lud_pkg::POS_W-1:0]         out_row,
  input wire logic [lud_pkg::POS_W-1:0]         out_col,
  input wire logic signed [lud_pkg::DATA_W-1:0] out_lower_value,
  input wire logic signed [lud_pkg::DATA_W-1:0] out_upper_value,
  input wire logic                              out_run_end
);
  import lud_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_lower_value) && $stable(out_upper_value))
    else $error("stalled result changed");

  // no new request taken while a run is still streaming
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> in_stall)
    else $error("request taken mid run");

  // unit diagonal and zero upper part of L
  a_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row == out_col && out_lower_value == Q_ONE) ||
      (out_row < out_col && out_lower_value == '0) || (out_row > out_col))
    else $error("bad L shape");

  // zero lower part of U
  a_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row > out_col) |-> out_upper_value == '0)
    else $error("bad U shape");

endmodule

bind lu_doolittle_decompose lud_checker u_lud_checker (.*);

`default_nettype wire
